/* rtl/fixed_block_pool_allocator_macros.svh */
// assertion macros for the block pool allocator
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define FBPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fbpa assertion failed");

// next-cycle implication, disabled during reset
`define FBPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fbpa assertion failed");

`endif

/* rtl/fbpa_pkg.sv */
// shared types and constants for the block pool allocator
`default_nettype none
package fbpa_pkg;

    localparam int MAX_NODES  = 256;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int LINK_W     = NODE_W + 1;
    localparam int COUNT_W    = 9;
    localparam int NCOUNT_W   = 9;
    localparam int SIZE_W     = 12;
    localparam int STRIDE_W   = 13;
    localparam int OFFSET_W   = 20;
    localparam int PROD_W     = NODE_W + STRIDE_W;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LINK_W-1:0]   NULL_LINK  = LINK_W'(MAX_NODES);
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
    localparam logic [NCOUNT_W-1:0] NODES_RST  = NCOUNT_W'(MAX_NODES);
    localparam logic [NCOUNT_W-1:0] NODES_CAP  = NCOUNT_W'(MAX_NODES);
    localparam logic [STRIDE_W-1:0] STRIDE_ADD = STRIDE_W'(7);
    localparam logic [STRIDE_W-1:0] STRIDE_MSK = ~STRIDE_W'(3);
    localparam logic [OFFSET_W-1:0] HDR_BYTES  = OFFSET_W'(4);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_SIZE  = 1'd1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_INIT,
        S_REPORT
    } t_state;

    typedef struct packed {
        t_opcode           opcode;
        logic [NODE_W-1:0] node_index;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [NODE_W-1:0]   block_index;
        logic [OFFSET_W-1:0] block_offset;
        logic [COUNT_W-1:0]  in_use;
        logic [COUNT_W-1:0]  peak_in_use;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic init_start;
        logic init_step;
        logic exec_alloc;
        logic exec_free;
        logic exec_report;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic init_none;
        logic init_last;
    } t_dp_status;

endpackage
`default_nettype wire

/* rtl/fbpa_ram.sv */
// generic single-write, single-read ram with registered read
`default_nettype none
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/fbpa_ctrl.sv */
// controller state machine for the block pool allocator
`default_nettype none
module fbpa_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire fbpa_pkg::t_opcode   i_opcode,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire fbpa_pkg::t_dp_status i_status,
    output fbpa_pkg::t_dp_cmd        o_cmd
);

    fbpa_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_slot_free;
    logic             w_exec;

    assign o_in_ready  = (r_state == fbpa_pkg::S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_opcode)
                        fbpa_pkg::OP_ALLOC: n_state = fbpa_pkg::S_ALLOC;
                        fbpa_pkg::OP_FREE:  n_state = fbpa_pkg::S_FREE;
                        fbpa_pkg::OP_INIT:  n_state = i_status.init_none ?
                                                      fbpa_pkg::S_REPORT :
                                                      fbpa_pkg::S_INIT;
                        default:            n_state = fbpa_pkg::S_REPORT;
                    endcase
                end
            end
            fbpa_pkg::S_ALLOC, fbpa_pkg::S_FREE, fbpa_pkg::S_REPORT: begin
                if (w_slot_free) begin
                    n_state = fbpa_pkg::S_IDLE;
                end
            end
            fbpa_pkg::S_INIT: begin
                if (i_status.init_last) begin
                    n_state = fbpa_pkg::S_REPORT;
                end
            end
            default: n_state = fbpa_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            fbpa_pkg::S_IDLE: begin
                o_cmd.accept     = w_accept;
                o_cmd.rd_issue   = w_accept && (i_opcode == fbpa_pkg::OP_ALLOC);
                o_cmd.init_start = w_accept && (i_opcode == fbpa_pkg::OP_INIT);
            end
            fbpa_pkg::S_ALLOC:  o_cmd.exec_alloc  = w_slot_free;
            fbpa_pkg::S_FREE:   o_cmd.exec_free   = w_slot_free;
            fbpa_pkg::S_INIT:   o_cmd.init_step   = 1'b1;
            fbpa_pkg::S_REPORT: o_cmd.exec_report = w_slot_free;
            default: o_cmd = '0;
        endcase
    end

    // result valid flag
    assign w_exec = o_cmd.exec_alloc || o_cmd.exec_free || o_cmd.exec_report;
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbpa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

/* rtl/fbpa_dp.sv */
// datapath: free-list head, counters, link table and result register
`default_nettype none
module fbpa_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire fbpa_pkg::t_in_item                i_in_item,
    input  wire fbpa_pkg::t_dp_cmd                 i_cmd,
    output fbpa_pkg::t_dp_status                   o_status,
    output fbpa_pkg::t_out_item                    o_out_item
);

    logic [fbpa_pkg::NCOUNT_W-1:0] r_node_count;
    logic [fbpa_pkg::SIZE_W-1:0]   r_item_size;
    logic [fbpa_pkg::LINK_W-1:0]   r_head, n_head;
    logic [fbpa_pkg::COUNT_W-1:0]  r_used, n_used;
    logic [fbpa_pkg::COUNT_W-1:0]  r_peak, n_peak;
    logic [fbpa_pkg::NCOUNT_W-1:0] r_pool_size;
    logic [fbpa_pkg::NODE_W-1:0]   r_walk;
    logic [fbpa_pkg::NODE_W-1:0]   r_idx;
    fbpa_pkg::t_out_item           r_out, n_out;

    logic [fbpa_pkg::NCOUNT_W-1:0] w_init_n;
    logic                          w_init_last;
    logic [fbpa_pkg::LINK_W-1:0]   w_rd_link;
    logic                          w_ram_we;
    logic [fbpa_pkg::NODE_W-1:0]   w_ram_waddr;
    logic [fbpa_pkg::LINK_W-1:0]   w_ram_wdata;
    logic                          w_push;
    logic [fbpa_pkg::STRIDE_W-1:0] w_stride;
    logic [fbpa_pkg::PROD_W-1:0]   w_prod;
    logic [fbpa_pkg::OFFSET_W-1:0] w_offset;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= fbpa_pkg::NODES_RST;
            r_item_size  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fbpa_pkg::CFG_NODE_COUNT:
                    r_node_count <= i_cfg_data[fbpa_pkg::NCOUNT_W-1:0];
                fbpa_pkg::CFG_ITEM_SIZE:
                    r_item_size  <= i_cfg_data[fbpa_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // blocks linked at init, capped at the pool depth
    assign w_init_n = (r_node_count > fbpa_pkg::NODES_CAP) ? fbpa_pkg::NODES_CAP
                                                           : r_node_count;
    assign w_init_last = ((fbpa_pkg::NCOUNT_W'(r_walk) + fbpa_pkg::NCOUNT_W'(1))
                          == w_init_n);
    assign o_status.init_none = (w_init_n == '0);
    assign o_status.init_last = w_init_last;

    // free pushes only a used pool and an index inside it
    assign w_push = (r_used != '0) && (fbpa_pkg::NCOUNT_W'(r_idx) < r_pool_size);

    // link table write: init walk or free push
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_walk;
        w_ram_wdata = w_init_last ? fbpa_pkg::NULL_LINK
                                  : fbpa_pkg::LINK_W'(r_walk) + fbpa_pkg::LINK_W'(1);
        if (i_cmd.init_step) begin
            w_ram_we = 1'b1;
        end else if (i_cmd.exec_free && w_push) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_idx;
            w_ram_wdata = r_head;
        end
    end

    fbpa_ram #(
        .WIDTH (fbpa_pkg::LINK_W),
        .DEPTH (fbpa_pkg::MAX_NODES)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_head[fbpa_pkg::NODE_W-1:0]),
        .o_rd_data (w_rd_link)
    );

    // payload offset of the head block
    assign w_stride = (fbpa_pkg::STRIDE_W'(r_item_size) + fbpa_pkg::STRIDE_ADD)
                      & fbpa_pkg::STRIDE_MSK;
    assign w_prod   = fbpa_pkg::PROD_W'(r_head[fbpa_pkg::NODE_W-1:0])
                      * fbpa_pkg::PROD_W'(w_stride);
    assign w_offset = w_prod[fbpa_pkg::OFFSET_W-1:0] + fbpa_pkg::HDR_BYTES;

    // list and counter updates, result assembly
    always_comb begin
        n_head = r_head;
        n_used = r_used;
        n_peak = r_peak;
        n_out  = '0;
        n_out.status = fbpa_pkg::ST_OK;
        if (i_cmd.exec_alloc) begin
            if (r_head[fbpa_pkg::NODE_W]) begin
                n_out.status = fbpa_pkg::ST_EMPTY;
            end else begin
                n_head = w_rd_link;
                if (r_used != fbpa_pkg::COUNT_MAX) begin
                    n_used = r_used + fbpa_pkg::COUNT_W'(1);
                end
                if (n_used > r_peak) begin
                    n_peak = n_used;
                end
                n_out.block_index  = r_head[fbpa_pkg::NODE_W-1:0];
                n_out.block_offset = w_offset;
            end
        end else if (i_cmd.exec_free) begin
            if (r_used == '0) begin
                n_out.status = fbpa_pkg::ST_UNDERFLOW;
            end else if (w_push) begin
                n_head = fbpa_pkg::LINK_W'(r_idx);
                n_used = r_used - fbpa_pkg::COUNT_W'(1);
            end
        end
        n_out.in_use      = n_used;
        n_out.peak_in_use = n_peak;
    end

    // free-list head and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= fbpa_pkg::NULL_LINK;
            r_used      <= '0;
            r_peak      <= '0;
            r_pool_size <= '0;
            r_walk      <= '0;
        end else if (i_cmd.init_start) begin
            r_head      <= (w_init_n == '0) ? fbpa_pkg::NULL_LINK : '0;
            r_used      <= '0;
            r_peak      <= '0;
            r_pool_size <= w_init_n;
            r_walk      <= '0;
        end else begin
            r_head <= n_head;
            r_used <= n_used;
            r_peak <= n_peak;
            if (i_cmd.init_step) begin
                r_walk <= r_walk + fbpa_pkg::NODE_W'(1);
            end
        end
    end

    // latched index of the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= i_in_item.node_index;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec_alloc || i_cmd.exec_free || i_cmd.exec_report) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

endmodule
`default_nettype wire

/* rtl/fixed_block_pool_allocator.sv */
// alloc, free and no-op pass through their execute state and raise the result once the output slot is free
// init walks the link table one entry per cycle over min(node_count, 256) entries, then reports
// a transaction is accepted only in the idle state, so no new request enters until the current one executes
// a registered result lets the next transaction enter while a result waits
// reset (synchronous, active low) empties the pool; link table is not cleared
`default_nettype none
`include "fixed_block_pool_allocator_macros.svh"
module fixed_block_pool_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fbpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire fbpa_pkg::t_in_item              i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output fbpa_pkg::t_out_item                  o_out_item
);

    fbpa_pkg::t_dp_cmd    w_cmd;
    fbpa_pkg::t_dp_status w_status;
    logic                 w_in_fire;
    logic                 w_peak_ok;
    logic                 w_underflow;

    // controller
    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_item.opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath
    fbpa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_item (o_out_item)
    );

    // terms used by the checks
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_peak_ok   = (o_out_item.peak_in_use >= o_out_item.in_use);
    assign w_underflow = o_out_valid && (o_out_item.status == fbpa_pkg::ST_UNDERFLOW);

    // checks
    `FBPA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_in_fire, !o_in_ready)
    `FBPA_ASSERT_IMP(a_peak_covers_use, i_clk, i_rst_n, o_out_valid, w_peak_ok)
    `FBPA_ASSERT_IMP(a_underflow_zero, i_clk, i_rst_n, w_underflow, o_out_item.in_use == '0)

endmodule
`default_nettype wire
